### hw/rtl/hlsr_pkg.sv
// Shared types and constants for the hopping link sync receiver.
package hlsr_pkg;

    localparam int CHAN_W    = 7;
    localparam int TABLE_N   = 8;
    localparam int TABLE_W   = CHAN_W * TABLE_N;
    localparam int PERIOD_W  = 24;
    localparam int LOSS_W    = 8;
    localparam int RETRY_W   = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = TABLE_W;

    localparam logic [CFG_IDX_W-1:0] REG_CHAN_TABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOSS_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_PER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_WAIT_PER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OPERATE_PER  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OP_ACK_PER   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BCAST        = 3'd7;

    typedef enum logic [1:0] {
        CMD_TIMER = 2'd0,
        CMD_RX    = 2'd1,
        CMD_SCAN  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        MODE_SEARCH   = 3'b001,
        MODE_WAIT_ACK = 3'b010,
        MODE_OPERATE  = 3'b100
    } t_mode;

    typedef enum logic [1:0] {
        NOTE_NONE  = 2'd0,
        NOTE_BCAST = 2'd1,
        NOTE_REPLY = 2'd2
    } t_notify;

    typedef struct packed {
        logic [TABLE_W-1:0]  chan_table;
        logic [LOSS_W-1:0]   loss_limit;
        logic [RETRY_W-1:0]  retry_limit;
        logic [PERIOD_W-1:0] search_period;
        logic [PERIOD_W-1:0] ack_wait_period;
        logic [PERIOD_W-1:0] operate_period;
        logic [PERIOD_W-1:0] operate_ack_period;
        logic                broadcast_listener;
    } t_cfg;

    typedef struct packed {
        logic                stop_rx;
        logic                set_chan;
        logic [CHAN_W-1:0]   chan_num;
        logic                start_rx;
        logic                clear_timer;
        logic                load_period;
        logic [PERIOD_W-1:0] timer_period;
        t_notify             notify;
    } t_action;

endpackage

### hw/rtl/hlsr_core.sv
// Link mode state and per-event action word generation.
module hlsr_core
    import hlsr_pkg::*;
#(
    parameter int NUM_CHANNELS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [1:0]         i_cmd,
    input  logic [RETRY_W-1:0] i_retry_count,
    input  t_cfg               i_cfg,
    output t_action            o_action
);

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHANNELS - 1);
    localparam logic [LOSS_W-1:0] LOSS_MAX = '1;

    t_mode             r_mode, n_mode;
    logic              r_rx_en, n_rx_en;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [LOSS_W-1:0] r_missed, n_missed;
    logic              r_got, n_got;
    logic              r_ackp, n_ackp;

    logic [IDX_W-1:0]  w_idx_inc;
    t_action           w_act;

    assign w_idx_inc = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;

    always_comb begin
        n_mode   = r_mode;
        n_rx_en  = r_rx_en;
        n_idx    = r_idx;
        n_missed = r_missed;
        n_got    = r_got;
        n_ackp   = r_ackp;
        w_act    = '0;
        w_act.notify = NOTE_NONE;
        case (t_cmd'(i_cmd))
            CMD_TIMER: begin
                unique case (r_mode)
                    MODE_SEARCH: begin
                        w_act.clear_timer = 1'b1;
                        if (r_rx_en) begin
                            n_rx_en       = 1'b0;
                            w_act.stop_rx = 1'b1;
                        end else begin
                            n_rx_en        = 1'b1;
                            n_idx          = w_idx_inc;
                            w_act.set_chan = 1'b1;
                            w_act.chan_num =
                                i_cfg.chan_table[CHAN_W*int'(w_idx_inc) +: CHAN_W];
                            w_act.start_rx = 1'b1;
                        end
                    end
                    MODE_WAIT_ACK: begin
                        w_act.stop_rx      = 1'b1;
                        n_mode             = MODE_OPERATE;
                        w_act.clear_timer  = 1'b1;
                        w_act.load_period  = 1'b1;
                        w_act.timer_period = i_cfg.operate_ack_period;
                        n_got              = 1'b1;
                        n_ackp             = 1'b1;
                    end
                    default: begin
                        priority if (r_missed == i_cfg.loss_limit) begin
                            n_mode             = MODE_SEARCH;
                            w_act.load_period  = 1'b1;
                            w_act.timer_period = i_cfg.search_period;
                            n_got              = 1'b0;
                        end else if (r_got) begin
                            w_act.clear_timer  = 1'b1;
                            w_act.load_period  = 1'b1;
                            w_act.timer_period = i_cfg.operate_period;
                            w_act.stop_rx      = ~r_ackp;
                            w_act.set_chan     = 1'b1;
                            w_act.chan_num     =
                                i_cfg.chan_table[CHAN_W*int'(r_idx) +: CHAN_W];
                            n_idx              = w_idx_inc;
                            n_ackp             = 1'b0;
                        end else if (r_missed != LOSS_MAX) begin
                            n_missed = r_missed + 1'b1;
                        end
                        w_act.start_rx = 1'b1;
                    end
                endcase
            end
            CMD_RX: begin
                if (i_retry_count <= i_cfg.retry_limit) begin
                    n_got = 1'b1;
                end
                w_act.notify       = i_cfg.broadcast_listener ? NOTE_BCAST : NOTE_REPLY;
                n_mode             = MODE_WAIT_ACK;
                w_act.clear_timer  = 1'b1;
                w_act.load_period  = 1'b1;
                w_act.timer_period = i_cfg.ack_wait_period;
                n_missed           = '0;
            end
            CMD_SCAN: begin
                n_mode             = MODE_SEARCH;
                w_act.load_period  = 1'b1;
                w_act.timer_period = i_cfg.search_period;
                w_act.start_rx     = 1'b1;
                n_rx_en            = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_action = w_act;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_SEARCH;
            r_rx_en  <= 1'b0;
            r_idx    <= '0;
            r_missed <= '0;
            r_got    <= 1'b0;
            r_ackp   <= 1'b0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_rx_en  <= n_rx_en;
            r_idx    <= n_idx;
            r_missed <= n_missed;
            r_got    <= n_got;
            r_ackp   <= n_ackp;
        end
    end

    a_rx_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_cmd == CMD_RX) |=> (r_missed == '0 && r_mode == MODE_WAIT_ACK))
        else $error("reception did not enter ack wait");

    a_scan_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_cmd == CMD_SCAN) |=> (r_rx_en && r_mode == MODE_SEARCH))
        else $error("scan did not enter search");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LAST_IDX)
        else $error("channel index out of range");

endmodule

### hw/rtl/hopping_link_sync_receiver.sv
// Top level of the hopping link sync receiver: config registers and output buffering.
//
// Input channel: i_in_valid / o_in_stall carry one event word (i_cmd, i_retry_count).
// Output channel: o_out_valid / i_out_stall carry one action word per event.
// Each accepted event updates the link state at the accepting edge and its action
// word is registered in the output register, or in the skid register when it is full.
// One event per cycle unless stalled; the state update is a single registered pass.
// A two-entry output buffer (output register plus skid register) lets the input
// keep accepting while a result waits; o_in_stall rises only when both entries
// are full and is a registered signal.
// When the receiver stalls, the pending word holds steady on the output ports.
// Reset (synchronous, active low) clears the link state to search mode with the
// receiver flag, channel index, loss counter and flags at zero, empties the output
// buffer and loads the register defaults. Config writes via i_cfg_we take
// effect at the next edge and are meant to happen while the block is idle.
module hopping_link_sync_receiver
    import hlsr_pkg::*;
#(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_cmd,
    input  logic [RETRY_W-1:0]   i_retry_count,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_stop_rx,
    output logic                 o_set_chan,
    output logic [CHAN_W-1:0]    o_chan_num,
    output logic                 o_start_rx,
    output logic                 o_clear_timer,
    output logic                 o_load_period,
    output logic [PERIOD_W-1:0]  o_timer_period,
    output logic [1:0]           o_notify,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg    r_cfg;
    t_action w_action;
    t_action r_out, r_skid;
    logic    r_out_valid, r_skid_valid;
    logic    w_accept, w_take;

    assign o_in_stall = r_skid_valid;
    assign w_accept   = i_in_valid && !r_skid_valid;
    assign w_take     = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.chan_table         <= '0;
            r_cfg.loss_limit         <= LOSS_W'(10);
            r_cfg.retry_limit        <= RETRY_W'(3);
            r_cfg.search_period      <= PERIOD_W'(3277);
            r_cfg.ack_wait_period    <= PERIOD_W'(33);
            r_cfg.operate_period     <= PERIOD_W'(328);
            r_cfg.operate_ack_period <= PERIOD_W'(295);
            r_cfg.broadcast_listener <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CHAN_TABLE:   r_cfg.chan_table         <= i_cfg_data[TABLE_W-1:0];
                REG_LOSS_LIMIT:   r_cfg.loss_limit         <= i_cfg_data[LOSS_W-1:0];
                REG_RETRY_LIMIT:  r_cfg.retry_limit        <= i_cfg_data[RETRY_W-1:0];
                REG_SEARCH_PER:   r_cfg.search_period      <= i_cfg_data[PERIOD_W-1:0];
                REG_ACK_WAIT_PER: r_cfg.ack_wait_period    <= i_cfg_data[PERIOD_W-1:0];
                REG_OPERATE_PER:  r_cfg.operate_period     <= i_cfg_data[PERIOD_W-1:0];
                REG_OP_ACK_PER:   r_cfg.operate_ack_period <= i_cfg_data[PERIOD_W-1:0];
                REG_BCAST:        r_cfg.broadcast_listener <= i_cfg_data[0];
            endcase
        end
    end

    hlsr_core #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_cmd        (i_cmd),
        .i_retry_count(i_retry_count),
        .i_cfg        (r_cfg),
        .o_action     (w_action)
    );

    // output register plus skid word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (w_accept) begin
            if (!r_out_valid || w_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (w_accept) begin
            if (!r_out_valid || w_take) begin
                r_out <= w_action;
            end else begin
                r_skid <= w_action;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_stop_rx      = r_out.stop_rx;
    assign o_set_chan     = r_out.set_chan;
    assign o_chan_num     = r_out.chan_num;
    assign o_start_rx     = r_out.start_rx;
    assign o_clear_timer  = r_out.clear_timer;
    assign o_load_period  = r_out.load_period;
    assign o_timer_period = r_out.timer_period;
    assign o_notify       = r_out.notify;

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held without output word");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_out_valid && i_out_stall) |=> r_skid_valid)
        else $error("word accepted under stall was not buffered");

    a_chan_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.set_chan) |-> (r_out.chan_num == '0))
        else $error("channel number without set_chan");

    a_period_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.load_period) |-> (r_out.timer_period == '0))
        else $error("timer period without load");

endmodule
